@@ src/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by the top level.
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } lkvc_req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } lkvc_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_READV,
        ST_UPD,
        ST_UPD_END,
        ST_DONE
    } lkvc_state_t;

endpackage

`default_nettype wire

@@ src/lkvc_mem.sv @@
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No package dependency.
`default_nettype none

module lkvc_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/lru_key_value_cache_core.sv @@
// Top level of the LRU key-value cache: control sequencer and datapath.
// Depends on lkvc_pkg (types, codes) and lkvc_mem (key, value and rank RAMs).
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Each item on s_data is a get or a set with a key and a value; each one
// yields exactly one item on m_data: hit says the key was present, and
// read_value carries the stored value on a get hit (zero otherwise).
// Keys, values and recency ranks sit in three synchronous RAMs; only the
// per-entry valid bits and the entry count are flip-flops. Items are
// handled one at a time. A request scans every slot through the RAM read
// port (plus a closing state for the read latency), takes a decision
// state, and, when the recency order changes, sweeps the rank RAM a second
// time as a read-modify-write pass; a get hit also reads its value first.
// A finished result waits in the output register, so the next item is
// taken while the previous result is still pending. The capacity
// register (cfg_wr_en/cfg_wr_data) must be written only while idle; the
// block itself does not enforce it. Zero acts as one, and values above
// MAX_ENTRIES saturate.
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lkvc_pkg::lkvc_req_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lkvc_pkg::lkvc_rsp_t             m_data
);

    import lkvc_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0] ONE_CMP  = CMP_W'(1);

    // ---- state -----------------------------------------------------------
    lkvc_state_t state_reg, state_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    lkvc_req_t        req_reg, req_next;

    // pass address counter and read pipeline tracking
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // scan results: matching slot, eviction victim, first free slot
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_slot_reg, found_slot_next;
    logic [RANK_W-1:0] found_rank_reg, found_rank_next;
    logic              any_reg, any_next;
    logic [IDX_W-1:0]  vict_slot_reg, vict_slot_next;
    logic [RANK_W-1:0] vict_rank_reg, vict_rank_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_slot_reg, free_slot_next;

    // promotion: target slot and rank limit for the update pass
    logic [IDX_W-1:0]  tgt_slot_reg, tgt_slot_next;
    logic              lim_all_reg, lim_all_next;
    logic [RANK_W-1:0] lim_rank_reg, lim_rank_next;

    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // staged result and output register
    logic                    res_hit_reg, res_hit_next;
    logic signed [VAL_W-1:0] res_value_reg, res_value_next;
    logic                    m_valid_reg, m_valid_next;
    lkvc_rsp_t               m_data_reg, m_data_next;

    // ---- RAM ports -------------------------------------------------------
    logic              kv_we_key, kv_we_val;
    logic [IDX_W-1:0]  kv_wr_slot;
    logic [KEY_W-1:0]  key_rd;
    logic [VAL_W-1:0]  val_rd;
    logic              rank_we;
    logic [RANK_W-1:0] rank_wdata;
    logic [RANK_W-1:0] rank_rd;

    // ---- derived ---------------------------------------------------------
    logic [CMP_W-1:0] cap_ext, cap_eff;
    logic             store_full;
    logic             rd_valid;
    logic             key_match;

    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            cap_eff = ONE_CMP;
        end else if (cap_ext > MAX_CMP) begin
            cap_eff = MAX_CMP;
        end else begin
            cap_eff = cap_ext;
        end
        store_full = (CMP_W'(count_reg) >= cap_eff);
        rd_valid   = valid_reg[rd_idx_reg];
        key_match  = (key_rd == $unsigned(req_reg.key));
    end

    lkvc_mem #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_mem (
        .aclk    (aclk),
        .wr_en   (kv_we_key),
        .wr_addr (kv_wr_slot),
        .wr_data ($unsigned(req_reg.key)),
        .rd_addr (cnt_reg),
        .rd_data (key_rd)
    );

    // value read address is the hit slot; used only for the get-hit read
    lkvc_mem #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_mem (
        .aclk    (aclk),
        .wr_en   (kv_we_val),
        .wr_addr (kv_wr_slot),
        .wr_data ($unsigned(req_reg.value)),
        .rd_addr (found_slot_reg),
        .rd_data (val_rd)
    );

    // rank RAM: read ahead by one slot, written back behind the read
    lkvc_mem #(.WIDTH(RANK_W), .DEPTH(MAX_ENTRIES)) u_rank_mem (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (rd_idx_reg),
        .wr_data (rank_wdata),
        .rd_addr (cnt_reg),
        .rd_data (rank_rd)
    );

    // ---- next state ------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (found_reg) begin
                    state_next = (req_reg.cmd == CMD_GET) ? ST_READV : ST_UPD;
                end else if (req_reg.cmd == CMD_GET) begin
                    state_next = ST_DONE;
                end else if (store_full) begin
                    state_next = any_reg ? ST_UPD : ST_DONE;
                end else begin
                    state_next = free_found_reg ? ST_UPD : ST_DONE;
                end
            end
            ST_READV: state_next = ST_UPD;
            ST_UPD: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_UPD_END;
                end
            end
            ST_UPD_END: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- outputs and datapath -------------------------------------------
    always_comb begin
        s_ready = (state_reg == ST_IDLE);

        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        req_next        = req_reg;
        cnt_next        = '0;
        pend_next       = (state_reg == ST_SCAN) || (state_reg == ST_UPD);
        rd_idx_next     = cnt_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        found_rank_next = found_rank_reg;
        any_next        = any_reg;
        vict_slot_next  = vict_slot_reg;
        vict_rank_next  = vict_rank_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        tgt_slot_next   = tgt_slot_reg;
        lim_all_next    = lim_all_reg;
        lim_rank_next   = lim_rank_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        res_hit_next    = res_hit_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        kv_we_key  = 1'b0;
        kv_we_val  = 1'b0;
        kv_wr_slot = found_slot_reg;
        rank_we    = 1'b0;
        rank_wdata = '0;

        if ((state_reg == ST_SCAN) || (state_reg == ST_UPD)) begin
            cnt_next = cnt_reg + IDX_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next        = s_data;
                    found_next      = 1'b0;
                    any_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            ST_SCAN, ST_SCAN_END: begin
                if (pend_reg) begin
                    if (rd_valid && key_match && !found_reg) begin
                        found_next      = 1'b1;
                        found_slot_next = rd_idx_reg;
                        found_rank_next = rank_rd;
                    end
                    // least recent = highest rank among valid slots
                    if (rd_valid && (!any_reg || rank_rd > vict_rank_reg)) begin
                        any_next       = 1'b1;
                        vict_slot_next = rd_idx_reg;
                        vict_rank_next = rank_rd;
                    end
                    if (!rd_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_slot_next  = rd_idx_reg;
                    end
                end
            end
            ST_DECIDE: begin
                res_hit_next   = found_reg;
                res_value_next = '0;
                if (found_reg) begin
                    tgt_slot_next = found_slot_reg;
                    lim_all_next  = 1'b0;
                    lim_rank_next = found_rank_reg;
                    if (req_reg.cmd == CMD_SET) begin
                        kv_we_val  = 1'b1;
                        kv_wr_slot = found_slot_reg;
                    end
                end else if (req_reg.cmd == CMD_SET) begin
                    if (store_full) begin
                        // evict: new pair reuses the victim slot
                        if (any_reg) begin
                            kv_we_key     = 1'b1;
                            kv_we_val     = 1'b1;
                            kv_wr_slot    = vict_slot_reg;
                            tgt_slot_next = vict_slot_reg;
                            lim_all_next  = 1'b1;
                        end
                    end else if (free_found_reg) begin
                        kv_we_key                 = 1'b1;
                        kv_we_val                 = 1'b1;
                        kv_wr_slot                = free_slot_reg;
                        tgt_slot_next             = free_slot_reg;
                        lim_all_next              = 1'b1;
                        valid_next[free_slot_reg] = 1'b1;
                        count_next                = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_READV: begin
                res_value_next = $signed(val_rd);
            end
            ST_UPD, ST_UPD_END: begin
                if (pend_reg) begin
                    if (rd_idx_reg == tgt_slot_reg) begin
                        rank_we    = 1'b1;
                        rank_wdata = '0;
                    end else if (rd_valid && (lim_all_reg || rank_rd < lim_rank_reg)) begin
                        rank_we    = 1'b1;
                        rank_wdata = rank_rd + RANK_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.hit        = res_hit_reg;
                    m_data_next.read_value = res_value_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // ---- registers -------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            pend_reg    <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            pend_reg    <= pend_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        cnt_reg        <= cnt_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        found_slot_reg <= found_slot_next;
        found_rank_reg <= found_rank_next;
        any_reg        <= any_next;
        vict_slot_reg  <= vict_slot_next;
        vict_rank_reg  <= vict_rank_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        tgt_slot_reg   <= tgt_slot_next;
        lim_all_reg    <= lim_all_next;
        lim_rank_reg   <= lim_rank_next;
        res_hit_reg    <= res_hit_next;
        res_value_reg  <= res_value_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ bench/lru_cache_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the LRU key-value cache: watches both channels and the capacity port.
// Depends on lkvc_pkg for the item types and codes.

module lru_cache_checker #(
    parameter int DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  lkvc_pkg::lkvc_req_t         s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  lkvc_pkg::lkvc_rsp_t         m_data,
    output int                          fail_count,
    output int                          pending
);
    import lkvc_pkg::*;

    // shadow copy of the cache contents
    logic [KEY_W-1:0] key_tab [DEPTH];
    logic [VAL_W-1:0] val_tab [DEPTH];
    bit               used    [DEPTH];
    int unsigned      rank    [DEPTH];  // 0 = most recent
    int unsigned      fill;
    logic [CAP_W-1:0] cap_reg;
    lkvc_rsp_t        rsp_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // every live entry ranked below limit ages by one; s becomes most recent
    function automatic void make_recent(int unsigned s, int unsigned limit);
        for (int i = 0; i < DEPTH; i++) begin
            if (used[i] && i != s && rank[i] < limit) begin
                rank[i]++;
            end
        end
        rank[s] = 0;
    endfunction

    function automatic lkvc_rsp_t serve_request(lkvc_req_t req);
        lkvc_rsp_t   rsp;
        int unsigned eff_cap;
        int unsigned slot;
        bit          found;
        bit          any;
        rsp   = '0;
        found = 1'b0;
        any   = 1'b0;
        slot  = 0;
        if (cap_reg == 0) begin
            eff_cap = 1;
        end else if (cap_reg > DEPTH) begin
            eff_cap = DEPTH;
        end else begin
            eff_cap = cap_reg;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (!found && used[i] && key_tab[i] == req.key) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            rsp.hit = 1'b1;
            if (req.cmd == CMD_GET) begin
                rsp.read_value = val_tab[slot];
            end else begin
                val_tab[slot] = req.value;
            end
            make_recent(slot, rank[slot]);
        end else if (req.cmd == CMD_SET) begin
            if (fill >= eff_cap) begin
                // replace the least recent entry; count stays as it is
                for (int i = 0; i < DEPTH; i++) begin
                    if (used[i] && (!any || rank[i] > rank[slot])) begin
                        slot = i;
                        any  = 1'b1;
                    end
                end
                key_tab[slot] = req.key;
                val_tab[slot] = req.value;
                make_recent(slot, 32'hFFFF_FFFF);
            end else begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!any && !used[i]) begin
                        slot = i;
                        any  = 1'b1;
                    end
                end
                make_recent(slot, 32'hFFFF_FFFF);
                used[slot]    = 1'b1;
                key_tab[slot] = req.key;
                val_tab[slot] = req.value;
                fill++;
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        lkvc_rsp_t want;
        if (!aresetn) begin
            foreach (used[i]) begin
                used[i] = 1'b0;
                rank[i] = 0;
            end
            fill    = 0;
            cap_reg = CAP_RESET;
            rsp_q.delete();
        end else begin
            // results first, so a result can never match an item taken at the same edge
            if (m_valid && m_ready) begin
                if (rsp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item hit=%b read_value=%0d",
                                              m_data.hit, m_data.read_value));
                end else begin
                    want = rsp_q.pop_front();
                    if (m_data.hit !== want.hit) begin
                        report_mismatch($sformatf("hit %b, predicted %b",
                                                  m_data.hit, want.hit));
                    end
                    if (m_data.read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value %0d, predicted %0d",
                                                  m_data.read_value, want.read_value));
                    end
                end
            end
            if (cfg_wr_en) begin
                cap_reg = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                rsp_q.push_back(serve_request(s_data));
            end
        end
        pending = rsp_q.size();
    end

endmodule

@@ bench/tb_lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps
// Testbench top for lru_key_value_cache_core: stimulus, back-pressure and verdict.
// Depends on lkvc_pkg, the core itself and lru_cache_checker.

module tb_lru_key_value_cache_core;
    import lkvc_pkg::*;

    localparam int MAX_ENTRIES   = 16;
    localparam int RESET_CYCLES  = 7;
    // longest request is a get hit: two sweeps of the store plus its value read
    localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 8;
    localparam int HOLD_CYCLES   = 300;   // long sink stall, fills the core
    localparam int QUIET_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 72;
    localparam int POOL_MAX      = 24;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    lkvc_req_t        s_data      = '0;
    logic             m_ready     = 1'b0;
    logic             s_ready;
    logic             m_valid;
    lkvc_rsp_t        m_data;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit calm         = 1'b0;  // no idling on either side while set
    bit hold_req     = 1'b0;  // asks the sink for one long stall

    always #1 aclk = ~aclk;

    lru_key_value_cache_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    lru_cache_checker #(
        .DEPTH (MAX_ENTRIES)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result sink. Drops ready about 35% of cycles, never while calm,
    // and takes one long stall on request so the core backs up into s_ready.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 35);
            end
        end
    end

    // Offer one item and return at the edge that takes it. Gaps before an
    // item are mostly short, now and then long enough to land anywhere in
    // the core's two sweeps.
    task automatic request(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
        lkvc_req_t req;
        req.cmd   = cmd;
        req.key   = key;
        req.value = value;
        if (!calm && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3) == 0 ? $urandom_range(8, 45) : $urandom_range(1, 4))
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every predicted item has come back,
    // then leave the core idle for a settling time.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Capacity is only changed with the core drained.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL_MAX];
        logic [CAP_W-1:0] cap_list [RAND_PHASES];
        int               pool_size;
        logic [KEY_W-1:0] key;

        cap_list = '{5'd1, 5'd16, 5'd8, 5'd17, 5'd3, 5'd0, 5'd31, 5'd0};
        cap_list[RAND_PHASES-1] = CAP_W'($urandom_range(31));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-store miss, extreme keys and values, set hit,
        // get hit with a junk value field, at reset capacity.
        request(CMD_GET, 32'h0000_0000, 32'h5A5A_5A5A);
        request(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        request(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        request(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
        request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        request(CMD_SET, 32'h0000_0000, 32'h1234_5678);
        request(CMD_GET, 32'h0000_0000, 32'h0000_0000);

        // Capacity zero behaves as one, and sits below the four live
        // entries: each set miss swaps out the oldest, count unchanged.
        set_capacity(5'd0);
        request(CMD_SET, 32'h0000_0005, 32'h0000_0005);
        request(CMD_SET, 32'h0000_0006, 32'h0000_0006);
        request(CMD_GET, 32'h0000_0005, 32'h0000_0000);

        // Oversized capacity saturates: fill all slots, then one more evicts.
        set_capacity(5'd31);
        for (int i = 0; i < MAX_ENTRIES - 3; i++) begin
            request(CMD_SET, 32'h0000_0100 + i, $urandom);
        end

        // Random phases, one capacity each. Keys mostly come from a small
        // pool so hits, updates and evictions all happen; a few are fresh.
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_capacity(cap_list[p]);
            pool_size = $urandom_range(2, POOL_MAX);
            foreach (key_pool[i]) begin
                key_pool[i] = $urandom;
            end
            if ($urandom_range(1)) begin
                key_pool[0] = 32'h8000_0000;
            end
            calm = (p == 1);  // one long run with both sides always ready
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 10) begin
                    hold_req <= 1'b1;
                end
                key = ($urandom_range(19) == 0) ? $urandom
                                                : key_pool[$urandom_range(pool_size - 1)];
                request(1'($urandom_range(1)), key, $urandom);
            end
            calm = 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
